[rtl/serial_frame_deframer_top_assert.svh]
// Assertion macros for the serial frame deframer.
`ifndef SERIAL_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define SERIAL_FRAME_DEFRAMER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SFD_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sfd assertion failed");
`define SFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfd assertion failed");
`else
`define SFD_ASSERT_SAME(label, clk, rst, ante, cons)
`define SFD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/sfd_pkg.sv]
package sfd_pkg;

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_LENGTH = 2'd1,
    PH_BODY   = 2'd2
  } sfd_phase_t;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_GOOD     = 3'd1,
    EV_BAD      = 3'd2,
    EV_TIMEOUT  = 3'd3,
    EV_OVERSIZE = 3'd4
  } sfd_event_t;

  localparam logic [7:0] HDR0 = 8'hFA;
  localparam logic [7:0] HDR1 = 8'hFB;
  localparam logic [7:0] TRL0 = 8'hFC;
  localparam logic [7:0] TRL1 = 8'hFD;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 1'b1;

  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd256;
  localparam logic [15:0] TIMEOUT_RST     = 16'd100;
  localparam logic [15:0] TICKS_MAX       = 16'hFFFF;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } sfd_item_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    sfd_event_t  frame_event;
    logic [15:0] frame_length;
  } sfd_result_t;

endpackage

[rtl/sfd_in_if.sv]
interface sfd_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;

  modport source (output valid, output action, output rx_byte, input ready);
  modport sink (input valid, input action, input rx_byte, output ready);
endinterface

[rtl/sfd_out_if.sv]
interface sfd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        payload_valid;
  logic [2:0]  frame_event;
  logic [15:0] frame_length;

  modport source (output valid, output payload_byte, output payload_valid,
                  output frame_event, output frame_length, input ready);
  modport sink (input valid, input payload_byte, input payload_valid,
                input frame_event, input frame_length, output ready);
endinterface

[rtl/serial_frame_deframer_top.sv]
// channel  dir  fields                                                    transfer
// din      in   action, rx_byte                                           valid & ready
// dout     out  payload_byte, payload_valid, frame_event, frame_length    valid & ready
// cfg      in   cfg_we, cfg_index, cfg_wdata                              cfg_we
//
// dout valid follows the din transfer through the input register, then the result register;
// one item per cycle sustained while dout is ready.
// The parser state updates in the same cycle the result register loads.
// Reset (rst, synchronous): parser idle hunting, max_payload 256, timeout_ticks 100.
// A stalled dout holds the result; din takes one more item into the input register.
`include "serial_frame_deframer_top_assert.svh"

module serial_frame_deframer_top import sfd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  sfd_in_if.sink               din,
  sfd_out_if.source            dout,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_wdata
);

  logic        item_valid;
  sfd_item_t   item;
  logic        out_free;
  logic        load;
  sfd_result_t res;
  logic        out_quiet;
  logic        out_stall;

  assign load = item_valid && out_free;

  sfd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .din        (din),
    .take       (load),
    .item_valid (item_valid),
    .item       (item)
  );

  sfd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .load      (load),
    .item      (item),
    .res       (res)
  );

  sfd_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (load),
    .res_in (res),
    .free   (out_free),
    .dout   (dout)
  );

  assign out_quiet = !dout.payload_valid && (dout.frame_event == EV_NONE) &&
                     (dout.frame_length == 16'd0);
  assign out_stall = dout.valid && !dout.ready;

  `SFD_ASSERT_NEXT(a_load_fills_out, clk, rst, load, dout.valid)
  `SFD_ASSERT_NEXT(a_tick_quiet, clk, rst, load && item.action, out_quiet)
  `SFD_ASSERT_SAME(a_payload_no_event, clk, rst, dout.valid && dout.payload_valid, dout.frame_event == EV_NONE)
  `SFD_ASSERT_NEXT(a_stall_hold, clk, rst, out_stall, dout.valid && $stable(dout.frame_length))

endmodule

[rtl/sfd_in_stage.sv]
module sfd_in_stage import sfd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  sfd_in_if.sink    din,
  input  logic      take,
  output logic      item_valid,
  output sfd_item_t item
);

  logic accept;

  assign din.ready = !item_valid || take;
  assign accept    = din.valid && din.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.action  <= din.action;
      item.rx_byte <= din.rx_byte;
    end
  end

endmodule

[rtl/sfd_parser.sv]
module sfd_parser import sfd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_wdata,
  input  logic                 load,
  input  sfd_item_t            item,
  output sfd_result_t          res
);

  logic [15:0] max_payload;
  logic [15:0] timeout_ticks;

  sfd_phase_t  phase, phase_next;
  logic [16:0] byte_count, byte_count_next;
  logic [7:0]  held_byte, held_byte_next;
  logic [7:0]  length_high, length_high_next;
  logic [15:0] payload_length, payload_length_next;
  logic [7:0]  running_sum, running_sum_next;
  logic        tail_ok, tail_ok_next;
  logic [15:0] elapsed_ticks, elapsed_ticks_next;

  logic [7:0]  b;
  logic [15:0] len_word;
  logic [16:0] len_ext;
  logic        oversize;
  logic        timed_out;
  logic        in_payload;
  logic        at_sum;
  logic        at_trl0;
  logic        hunt_hit;
  logic        ovs_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload   <= MAX_PAYLOAD_RST;
      timeout_ticks <= TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_PAYLOAD: max_payload   <= cfg_wdata;
        CFG_TIMEOUT:     timeout_ticks <= cfg_wdata;
        default:         ;
      endcase
    end
  end

  assign b          = item.rx_byte;
  assign len_word   = {length_high, b};
  assign len_ext    = {1'b0, payload_length};
  assign oversize   = len_word > max_payload;
  assign timed_out  = elapsed_ticks >= timeout_ticks;
  assign in_payload = byte_count < len_ext;
  assign at_sum     = byte_count == len_ext;
  assign at_trl0    = byte_count == len_ext + 17'd1;
  assign hunt_hit   = (byte_count == 17'd1) && (held_byte == HDR0) && (b == HDR1);
  assign ovs_hit    = (length_high == HDR0) && (b == HDR1);

  // next state
  always_comb begin
    phase_next          = phase;
    byte_count_next     = byte_count;
    held_byte_next      = held_byte;
    length_high_next    = length_high;
    payload_length_next = payload_length;
    running_sum_next    = running_sum;
    tail_ok_next        = tail_ok;
    elapsed_ticks_next  = elapsed_ticks;
    if (item.action) begin
      if (elapsed_ticks != TICKS_MAX) begin
        elapsed_ticks_next = elapsed_ticks + 16'd1;
      end
    end else begin
      unique case (phase)
        PH_LENGTH: begin
          priority if (byte_count == 17'd0) begin
            length_high_next = b;
            byte_count_next  = 17'd1;
          end else if (oversize) begin
            // recheck the two length bytes as a header
            held_byte_next = length_high;
            if (ovs_hit) begin
              phase_next      = PH_LENGTH;
              byte_count_next = 17'd0;
            end else begin
              phase_next      = PH_HUNT;
              held_byte_next  = b;
              byte_count_next = 17'd1;
            end
          end else begin
            payload_length_next = len_word;
            phase_next          = PH_BODY;
            byte_count_next     = 17'd0;
            running_sum_next    = 8'd0;
            tail_ok_next        = 1'b1;
            elapsed_ticks_next  = 16'd0;
          end
        end
        PH_BODY: begin
          priority if (timed_out) begin
            phase_next      = PH_HUNT;
            byte_count_next = 17'd0;
          end else if (in_payload) begin
            running_sum_next = running_sum + b;
            byte_count_next  = byte_count + 17'd1;
          end else if (at_sum) begin
            tail_ok_next    = tail_ok && (b == running_sum);
            byte_count_next = byte_count + 17'd1;
          end else if (at_trl0) begin
            tail_ok_next    = tail_ok && (b == TRL0);
            byte_count_next = byte_count + 17'd1;
          end else begin
            phase_next      = PH_HUNT;
            byte_count_next = 17'd0;
          end
        end
        default: begin
          if (hunt_hit) begin
            phase_next      = PH_LENGTH;
            byte_count_next = 17'd0;
          end else begin
            phase_next      = PH_HUNT;
            held_byte_next  = b;
            byte_count_next = 17'd1;
          end
        end
      endcase
    end
  end

  // result
  always_comb begin
    res = '{payload_byte: 8'd0, payload_valid: 1'b0, frame_event: EV_NONE,
            frame_length: 16'd0};
    if (!item.action) begin
      unique case (phase)
        PH_LENGTH: begin
          if ((byte_count != 17'd0) && oversize) begin
            res.frame_event  = EV_OVERSIZE;
            res.frame_length = len_word;
          end
        end
        PH_BODY: begin
          res.frame_length = payload_length;
          priority if (timed_out) begin
            res.frame_event = EV_TIMEOUT;
          end else if (in_payload) begin
            res.payload_byte  = b;
            res.payload_valid = 1'b1;
          end else if (at_sum || at_trl0) begin
            res.frame_event = EV_NONE;
          end else begin
            res.frame_event = (tail_ok && (b == TRL1)) ? EV_GOOD : EV_BAD;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      byte_count     <= 17'd0;
      held_byte      <= 8'd0;
      length_high    <= 8'd0;
      payload_length <= 16'd0;
      running_sum    <= 8'd0;
      tail_ok        <= 1'b1;
      elapsed_ticks  <= 16'd0;
    end else if (load) begin
      phase          <= phase_next;
      byte_count     <= byte_count_next;
      held_byte      <= held_byte_next;
      length_high    <= length_high_next;
      payload_length <= payload_length_next;
      running_sum    <= running_sum_next;
      tail_ok        <= tail_ok_next;
      elapsed_ticks  <= elapsed_ticks_next;
    end
  end

endmodule

[rtl/sfd_out_stage.sv]
module sfd_out_stage import sfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  sfd_result_t res_in,
  output logic        free,
  sfd_out_if.source   dout
);

  logic        valid;
  sfd_result_t res;

  assign free = !valid || dout.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (dout.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_in;
    end
  end

  assign dout.valid         = valid;
  assign dout.payload_byte  = res.payload_byte;
  assign dout.payload_valid = res.payload_valid;
  assign dout.frame_event   = res.frame_event;
  assign dout.frame_length  = res.frame_length;

endmodule
